[design/stbs_pkg.sv]
// Shared widths, operation codes and controller/datapath interface types for the bound search.
package stbs_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int VAL_W = 32;
    localparam int IDX_W = 8;
    localparam int POS_W = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_write;
        logic write;
        logic load;
        logic step;
        logic capture;
    } cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic lower_done;
        logic upper_done;
    } status_t;

endpackage

[design/stbs_ctrl.sv]
// Controller state machine for the bound search: handshakes and sequencing.
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    op,
    output logic    out_valid,
    input  logic    out_stall,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    output cmd_t    cmd,
    input  status_t status
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // The output register can take a new result when empty or being emptied.
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd.cfg_write = cfg_valid;
        cmd.write     = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.capture   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op == OP_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.lower_done && status.upper_done && out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

endmodule

[design/stbs_datapath.sv]
// Datapath for the bound search: table memory, two search windows and result registers.
module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic signed [VAL_W-1:0] search_key,
    input  logic [POS_W-1:0]        cfg_entry_count,
    output logic [POS_W-1:0]        lower_position,
    output logic [POS_W-1:0]        upper_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ($clog2(TABLE_DEPTH + 1) > POS_W) ? $clog2(TABLE_DEPTH + 1) : POS_W;
    localparam int WW = (AW > POS_W) ? AW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    function automatic logic [POS_W-1:0] midpoint(input logic [POS_W-1:0] lo,
                                                  input logic [POS_W-1:0] hi);
        logic [POS_W-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

    logic signed [VAL_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] key_reg;
    logic signed [VAL_W-1:0] rd_l_reg;
    logic signed [VAL_W-1:0] rd_u_reg;

    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_clamp;
    logic [POS_W-1:0] lo_l_reg;
    logic [POS_W-1:0] lo_l_next;
    logic [POS_W-1:0] hi_l_reg;
    logic [POS_W-1:0] hi_l_next;
    logic [POS_W-1:0] lo_u_reg;
    logic [POS_W-1:0] lo_u_next;
    logic [POS_W-1:0] hi_u_reg;
    logic [POS_W-1:0] hi_u_next;
    logic [POS_W-1:0] mid_l;
    logic [POS_W-1:0] mid_u;
    logic [POS_W-1:0] lower_pos_reg;
    logic [POS_W-1:0] upper_pos_reg;

    logic [WW-1:0] mid_l_ext;
    logic [WW-1:0] mid_u_ext;
    logic [WW-1:0] wr_idx_ext;
    logic [AW-1:0] rd_addr_l;
    logic [AW-1:0] rd_addr_u;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          done_l;
    logic          done_u;
    logic          go_l;
    logic          go_u;

    // Search only the entries the table actually holds.
    assign count_clamp = (CW'(count_reg) > DEPTH_C) ? DEPTH_C[POS_W-1:0] : count_reg;

    assign done_l = (lo_l_reg == hi_l_reg);
    assign done_u = (lo_u_reg == hi_u_reg);
    assign go_l   = (rd_l_reg < key_reg);
    assign go_u   = (rd_u_reg <= key_reg);
    assign mid_l  = midpoint(lo_l_reg, hi_l_reg);
    assign mid_u  = midpoint(lo_u_reg, hi_u_reg);

    always_comb
    begin
        lo_l_next = lo_l_reg;
        hi_l_next = hi_l_reg;
        lo_u_next = lo_u_reg;
        hi_u_next = hi_u_reg;
        if (cmd.load)
        begin
            lo_l_next = '0;
            hi_l_next = count_clamp;
            lo_u_next = '0;
            hi_u_next = count_clamp;
        end
        else if (cmd.step)
        begin
            if (!done_l)
            begin
                if (go_l)
                begin
                    lo_l_next = mid_l + POS_W'(1);
                end
                else
                begin
                    hi_l_next = mid_l;
                end
            end
            if (!done_u)
            begin
                if (go_u)
                begin
                    lo_u_next = mid_u + POS_W'(1);
                end
                else
                begin
                    hi_u_next = mid_u;
                end
            end
        end
    end

    // Each port reads the probe for the window the search moves to, so the
    // data is ready for the compare in the next cycle.
    assign mid_l_ext  = WW'(midpoint(lo_l_next, hi_l_next));
    assign mid_u_ext  = WW'(midpoint(lo_u_next, hi_u_next));
    assign rd_addr_l  = mid_l_ext[AW-1:0];
    assign rd_addr_u  = mid_u_ext[AW-1:0];
    assign wr_idx_ext = WW'(entry_index);
    assign wr_addr    = wr_idx_ext[AW-1:0];
    assign wr_en      = cmd.write && (CW'(entry_index) < DEPTH_C);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= entry_value;
        end
        rd_l_reg <= table_mem[rd_addr_l];
        rd_u_reg <= table_mem[rd_addr_u];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= search_key;
        end
        if (cmd.capture)
        begin
            lower_pos_reg <= lo_l_reg;
            upper_pos_reg <= lo_u_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lo_l_reg  <= '0;
            hi_l_reg  <= '0;
            lo_u_reg  <= '0;
            hi_u_reg  <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                count_reg <= cfg_entry_count;
            end
            lo_l_reg <= lo_l_next;
            hi_l_reg <= hi_l_next;
            lo_u_reg <= lo_u_next;
            hi_u_reg <= hi_u_next;
        end
    end

    assign status.lower_done = done_l;
    assign status.upper_done = done_u;
    assign lower_position    = lower_pos_reg;
    assign upper_position    = upper_pos_reg;

endmodule

[design/sorted_table_bound_search.sv]
// Top level of the sorted table bound search: controller, datapath and port checks.
//
// This block keeps a table of TABLE_DEPTH signed 32-bit entries, expected to be in
// non-decreasing order, and answers queries with two positions over the first
// entry_count entries: the lower bound (first entry not less than the key) and the
// upper bound (first entry greater than the key), each equal to the searched count
// when there is no such entry. A write transaction (op = 0) stores one entry, gives
// no result and does not stall the input; writes to an index at or beyond the
// table depth are dropped. A query transaction (op = 1) runs both binary searches
// side by side on the two read ports of the table memory, one halving step per
// clock, because each step's compare picks the address of the next read. After the
// query is accepted the input stays stalled while both searches run, until the
// result is captured into the output register. If the previous result is still
// waiting there when the search ends, the query holds at the end of its search,
// with the input stalled, until that result is taken. Results sit in an output
// register, so a new transaction can be accepted while the previous result is
// still waiting to be taken. The table has no reset and no clearing pass: only
// entries already written may be searched. entry_count is written through its
// own port, which is always ready, and should only be changed while no query is
// in flight.
module sorted_table_bound_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic signed [VAL_W-1:0] search_key,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [POS_W-1:0]        lower_position,
    output logic [POS_W-1:0]        upper_position,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [POS_W-1:0]        entry_count
);

    cmd_t    cmd;
    status_t status;

    // The controller owns the handshakes and the output valid flag.
    stbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the table, the count register and both search windows.
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .entry_index     (entry_index),
        .entry_value     (entry_value),
        .search_key      (search_key),
        .cfg_entry_count (entry_count),
        .lower_position  (lower_position),
        .upper_position  (upper_position)
    );

    // An accepted query must hold off the next transaction while it searches.
    a_query_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_QUERY) |=> in_stall)
        else $error("query accepted without stalling the input");

    // A write finishes at once, so the next transaction is never held off.
    a_write_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_WRITE) |=> !in_stall)
        else $error("write transaction stalled the input");

    // A new result only appears at the end of a search, when the input was stalled.
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search in progress");

endmodule
